// File: hw/rtl/tks_pkg.sv
// Shared types and constants for the streaming top-k selector.
package tks_pkg;

    localparam int MAX_KEEP_DEF   = 16;
    localparam int MAX_VOCAB_DEF  = 131072;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_W      = 5;
    localparam int TOKEN_W    = 17;
    localparam int RANK_W     = 4;
    localparam int OUT_DATA_W = ((TOKEN_W + RANK_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] KEEP_RESET = 5'd8;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } tks_state_t;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic load;        // insert the broadcast item into the sorted list
        logic shift_left;  // move every entry one place toward cell 0
    } tks_cell_ctrl_t;

endpackage

// File: hw/rtl/streaming_top_k_select_top.sv
// Streaming top-k selector: a chain of sorting cells and its row controller.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata logit_value, s_tlast row_end
//  m_      | out       | m_tvalid/m_tready  | m_tdata token_index, rank; m_tlast run_last
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data keep_count
//
// Every item inside a row is taken without a stall: all cells compare the new key
// at once and each shifts from its neighbor in the same edge.
// After the row-end item the list drains one result per cycle out of cell 0 while
// m_tready does not stall it; s_tready is low during the drain.
// A result waits in the output register while the next row is already taken.
// Reset (aresetn low, synchronous) empties the list and sets keep_count to 8.
module streaming_top_k_select_top #(
    parameter int MAX_KEEP   = tks_pkg::MAX_KEEP_DEF,
    parameter int MAX_VOCAB  = tks_pkg::MAX_VOCAB_DEF,
    parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // logit_value [VALUE_BITS-1:0], zero filled to whole bytes
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0]  s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // token_index [16:0], rank [20:17], zeros [23:21]
    output logic [tks_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_wr_en,
    input  logic [tks_pkg::CFG_W-1:0]              cfg_wr_data
);
    import tks_pkg::*;

    localparam int FILL_W = $clog2(MAX_KEEP + 1);
    localparam int IDX_W  = (MAX_VOCAB > 2) ? $clog2(MAX_VOCAB) : 1;
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_VOCAB - 1);

    tks_state_t            state_reg, state_next;
    logic [CFG_W-1:0]      keep_reg, keep_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]      tok_cnt_reg, tok_cnt_next;
    logic [FILL_W-1:0]     remain_reg, remain_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic                  m_valid_reg, m_valid_next;
    logic [TOKEN_W-1:0]    m_token_reg, m_token_next;
    logic [RANK_W-1:0]     m_rank_reg, m_rank_next;
    logic                  m_last_reg, m_last_next;

    logic [FILL_W-1:0]     keep_eff;
    logic [VALUE_BITS-1:0] key;
    logic                  accept;
    logic                  out_free;
    logic                  has_room;
    logic                  any_beat;
    tks_cell_ctrl_t        ctrl;

    logic [VALUE_BITS-1:0] cell_val [MAX_KEEP];
    logic [IDX_W-1:0]      cell_idx [MAX_KEEP];
    logic [MAX_KEEP-1:0]   lower_vec;
    logic [MAX_KEEP-1:0]   beat_vec;

    // Offset binary so that an unsigned compare orders signed scores.
    assign key = s_tdata[VALUE_BITS-1:0] ^ {1'b1, {(VALUE_BITS - 1){1'b0}}};

    assign keep_eff = (CMP_W'(keep_reg) > CMP_W'(MAX_KEEP)) ? FILL_W'(MAX_KEEP)
                                                             : FILL_W'(keep_reg);

    assign s_tready = (state_reg == ST_COLLECT);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign has_room = fill_reg < keep_eff;
    assign any_beat = |beat_vec;

    always_comb begin
        ctrl.load       = accept && (has_room || any_beat);
        ctrl.shift_left = (state_reg == ST_DRAIN) && out_free;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
            logic [VALUE_BITS-1:0] p_val, n_val;
            logic [IDX_W-1:0]      p_idx, n_idx;
            logic                  p_lower;
            if (gi == 0) begin : g_head
                assign p_val   = '0;
                assign p_idx   = '0;
                assign p_lower = 1'b0;
            end else begin : g_body
                assign p_val   = cell_val[gi-1];
                assign p_idx   = cell_idx[gi-1];
                assign p_lower = lower_vec[gi-1];
            end
            if (gi == MAX_KEEP - 1) begin : g_tail
                assign n_val = '0;
                assign n_idx = '0;
            end else begin : g_mid
                assign n_val = cell_val[gi+1];
                assign n_idx = cell_idx[gi+1];
            end

            tks_cell #(
                .VALUE_BITS (VALUE_BITS),
                .IDX_W      (IDX_W),
                .FILL_W     (FILL_W),
                .CELL_ID    (gi)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .fill       (fill_reg),
                .key_in     (key),
                .idx_in     (tok_cnt_reg),
                .prev_val   (p_val),
                .prev_idx   (p_idx),
                .prev_lower (p_lower),
                .next_val   (n_val),
                .next_idx   (n_idx),
                .val        (cell_val[gi]),
                .idx        (cell_idx[gi]),
                .lower      (lower_vec[gi]),
                .beat       (beat_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        keep_next    = cfg_wr_en ? cfg_wr_data : keep_reg;
        fill_next    = fill_reg;
        tok_cnt_next = tok_cnt_reg;
        remain_next  = remain_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_token_next = m_token_reg;
        m_rank_next  = m_rank_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_COLLECT: begin
                if (accept) begin
                    if (has_room) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (tok_cnt_reg != IDX_MAX) begin
                        tok_cnt_next = tok_cnt_reg + IDX_W'(1);
                    end
                    if (s_tlast) begin
                        // Results of the row: the list after this insert, capped at k.
                        remain_next  = has_room ? fill_reg + FILL_W'(1) : keep_eff;
                        rank_next    = '0;
                        fill_next    = '0;
                        tok_cnt_next = '0;
                        if ((has_room ? fill_reg + FILL_W'(1) : keep_eff) != '0) begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_token_next = TOKEN_W'(cell_idx[0]);
                    m_rank_next  = rank_reg;
                    m_last_next  = (remain_reg == FILL_W'(1));
                    rank_next    = rank_reg + RANK_W'(1);
                    remain_next  = remain_reg - FILL_W'(1);
                    if (remain_reg == FILL_W'(1)) begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            keep_reg    <= KEEP_RESET;
            fill_reg    <= '0;
            tok_cnt_reg <= '0;
            remain_reg  <= '0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            keep_reg    <= keep_next;
            fill_reg    <= fill_next;
            tok_cnt_reg <= tok_cnt_next;
            remain_reg  <= remain_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_token_reg <= m_token_next;
        m_rank_reg  <= m_rank_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - TOKEN_W - RANK_W)'(0), m_rank_reg, m_token_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: hw/rtl/tks_cell.sv
// One cell of the sorted chain: holds one (key, index) entry.
module tks_cell #(
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 17,
    parameter int FILL_W     = 5,
    parameter int CELL_ID    = 0
) (
    input  logic                      aclk,
    input  tks_pkg::tks_cell_ctrl_t   ctrl,
    input  logic [FILL_W-1:0]         fill,
    input  logic [VALUE_BITS-1:0]     key_in,
    input  logic [IDX_W-1:0]          idx_in,
    input  logic [VALUE_BITS-1:0]     prev_val,
    input  logic [IDX_W-1:0]          prev_idx,
    input  logic                      prev_lower,
    input  logic [VALUE_BITS-1:0]     next_val,
    input  logic [IDX_W-1:0]          next_idx,
    output logic [VALUE_BITS-1:0]     val,
    output logic [IDX_W-1:0]          idx,
    output logic                      lower,
    output logic                      beat
);
    import tks_pkg::*;

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  occupied;

    assign occupied = FILL_W'(CELL_ID) < fill;
    // The new key beats this entry only on a strictly greater key.
    assign beat  = occupied && (val_reg < key_in);
    // An empty cell counts as lower, so the insert point falls at the fill edge.
    assign lower = beat || !occupied;

    always_comb begin
        val_next = val_reg;
        idx_next = idx_reg;
        if (ctrl.shift_left) begin
            val_next = next_val;
            idx_next = next_idx;
        end else if (ctrl.load) begin
            if (prev_lower) begin
                val_next = prev_val;
                idx_next = prev_idx;
            end else if (lower) begin
                val_next = key_in;
                idx_next = idx_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        idx_reg <= idx_next;
    end

    assign val = val_reg;
    assign idx = idx_reg;

endmodule

// File: hw/rtl/tks_checker.sv
// Port-level checks for the streaming top-k selector, bound to the top level.
module tks_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  s_tlast,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [tks_pkg::OUT_DATA_W-1:0]        m_tdata,
    input logic                                  m_tlast
);
    import tks_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result payload changed while stalled");

    // Input is only held off after a row-end item was taken.
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("input stalled without a row end");

    // Results are loaded only while the list drains, when input is held off.
    a_valid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared outside a drain");

    // Within a row, results follow back to back with ascending rank.
    a_rank_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[TOKEN_W +: RANK_W] ==
                          $past(m_tdata[TOKEN_W +: RANK_W]) + RANK_W'(1))))
        else $error("rank did not advance by one");

endmodule

bind streaming_top_k_select_top tks_checker u_tks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
